[rtl/assert_macros.svh]
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define CTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cts_pkg.sv]
// Types and constants of the character token scanner.
`default_nettype none

package cts_pkg;

  localparam int NUMBER_BITS     = 32;
  localparam int IDENT_BITS      = 56;
  localparam int MAX_SLOTS       = 8;
  localparam int TERM_CHAR_BITS  = 8 * MAX_SLOTS;

  localparam int DEF_IDENT_CAPACITY = 8;
  localparam int DEF_VALUE_BITS     = 32;
  localparam int DEF_TERMINAL_SLOTS = 8;

  // configuration register indexes
  localparam logic [1:0] REG_TERMINAL_CHARS = 2'd0;
  localparam logic [1:0] REG_TERMINAL_COUNT = 2'd1;
  localparam logic [1:0] REG_SKIP_NEWLINES  = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_LO = 8'h66;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  typedef enum logic [2:0] {
    KIND_NEWLINE  = 3'd0,
    KIND_END      = 3'd1,
    KIND_HEX      = 3'd2,
    KIND_DEC      = 3'd3,
    KIND_IDENT    = 3'd4,
    KIND_UNKNOWN  = 3'd5,
    KIND_TERMINAL = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ZERO    = 3'd1,
    MODE_HEXX    = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_DEC     = 3'd4,
    MODE_IDENT   = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    kind_t                  token_kind;
    logic [2:0]             terminal_slot;
    logic [NUMBER_BITS-1:0] number_value;
    logic [IDENT_BITS-1:0]  ident_text;
    logic [2:0]             ident_length;
    logic [15:0]            token_line;
    logic [15:0]            token_column;
    logic                   last_of_run;
  } out_t;

  // tokens caused by one character: r1 valid only when two is set
  typedef struct packed {
    out_t r0;
    out_t r1;
    logic two;
  } pair_t;

endpackage

`default_nettype wire

[rtl/char_token_scanner.sv]
// Character token scanner: one character in, up to two tokens out.
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+-----------------------
//   in      | in_valid in_ready in_data        | in_valid & in_ready
//   out     | out_valid out_ready out_data     | out_valid & out_ready
//   cfg     | cfg_valid cfg_ready cfg_index    | cfg_valid & cfg_ready
//           | cfg_data                         |
//
// One character per cycle while in_ready is high; with the queue empty, a character's first token
// is visible the cycle after its transfer.
// Scan state updates in the accept cycle; tokens go to a two-entry queue
// of per-character token groups. A character giving two tokens presents
// them one after the other. in_ready drops only while both queue entries are taken.
// Reset (rst, synchronous) empties the queue and returns to line 1.
`default_nettype none

`include "assert_macros.svh"

module char_token_scanner #(
  parameter int IDENT_CAPACITY = cts_pkg::DEF_IDENT_CAPACITY,
  parameter int VALUE_BITS     = cts_pkg::DEF_VALUE_BITS,
  parameter int TERMINAL_SLOTS = cts_pkg::DEF_TERMINAL_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cts_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cts_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [cts_pkg::TERM_CHAR_BITS-1:0] cfg_data
);

  localparam int NB = cts_pkg::NUMBER_BITS;
  localparam int IB = cts_pkg::IDENT_BITS;
  localparam int IDENT_LIMIT = (IDENT_CAPACITY - 1 < 7) ? IDENT_CAPACITY - 1 : 7;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= cts_pkg::CHAR_ZERO && c <= cts_pkg::CHAR_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= cts_pkg::CHAR_LA && c <= cts_pkg::CHAR_LZ) ||
           (c >= cts_pkg::CHAR_UA && c <= cts_pkg::CHAR_UZ);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= cts_pkg::CHAR_LA && c <= cts_pkg::CHAR_LF_LO) ||
           (c >= cts_pkg::CHAR_UA && c <= cts_pkg::CHAR_UF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) v = c - cts_pkg::CHAR_ZERO;
    else if (c >= cts_pkg::CHAR_LA) v = c - cts_pkg::CHAR_LA + cts_pkg::HEX_ALPHA_BASE;
    else v = c - cts_pkg::CHAR_UA + cts_pkg::HEX_ALPHA_BASE;
    return v[3:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= cts_pkg::CHAR_UA && c <= cts_pkg::CHAR_UZ) ? (c | cts_pkg::CHAR_SPACE) : c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // configuration
  logic [cts_pkg::TERM_CHAR_BITS-1:0] terminal_chars;
  logic [3:0]                         terminal_count;
  logic                               skip_newlines;

  // scan state
  cts_pkg::mode_t        mode, mode_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [IB-1:0]         ibuf, ibuf_next;
  logic [2:0]            icnt, icnt_next;
  logic [15:0]           line, line_next, col, col_next;
  logic [15:0]           sline, sline_next, scol, scol_next;
  logic                  pcr, pcr_next, pbrk, pbrk_next;

  // result queue
  cts_pkg::pair_t q [2];
  logic [1:0]     q_count;
  logic           head_sub;

  logic           in_accept, out_accept, pop, push;
  logic           wr_pos;
  cts_pkg::pair_t pair_new;

  // combinational scan
  logic [7:0]     c, ch;
  logic           eot, chd, cha, chh, do_start, emit0, emit1;
  logic           term_hit;
  logic [2:0]     term_slot;
  cts_pkg::mode_t cur;
  cts_pkg::out_t  tok0, tok1;
  logic [VALUE_BITS-1:0] acc_x10;
  logic           icnt_ok;

  assign c   = in_data.char_code;
  assign eot = in_data.end_of_text;
  assign ch  = (c == cts_pkg::CHAR_BANG) ? cts_pkg::CHAR_LF : c;
  assign chd = !eot && is_digit(ch);
  assign cha = !eot && is_alpha(ch);
  assign chh = !eot && is_hex(ch);
  assign acc_x10 = (acc << 3) + (acc << 1) + VALUE_BITS'(ch[3:0]);

  // lowest matching slot wins
  always_comb begin
    term_hit  = 1'b0;
    term_slot = '0;
    for (int k = TERMINAL_SLOTS - 1; k >= 0; k--) begin
      if (4'(k) < terminal_count && terminal_chars[8*k +: 8] == ch) begin
        term_hit  = 1'b1;
        term_slot = 3'(k);
      end
    end
  end

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    ibuf_next  = ibuf;
    icnt_next  = icnt;
    line_next  = line;
    col_next   = col;
    sline_next = sline;
    scol_next  = scol;
    pcr_next   = pcr;
    pbrk_next  = pbrk;
    tok0       = '0;
    tok1       = '0;
    emit0      = 1'b0;
    emit1      = 1'b0;
    do_start   = 1'b0;
    cur        = mode;
    tok0.token_line   = sline;
    tok0.token_column = scol;

    if (!eot && mode == cts_pkg::MODE_COMMENT) begin
      if (c == cts_pkg::CHAR_LF) mode_next = cts_pkg::MODE_IDLE;
    end else if (!eot && pcr && c == cts_pkg::CHAR_LF) begin
      pcr_next = 1'b0;  // LF of CR LF
    end else begin
      cur       = (mode == cts_pkg::MODE_COMMENT) ? cts_pkg::MODE_IDLE : mode;
      mode_next = cur;
      if (pbrk) begin
        line_next = sat_inc(line);
        col_next  = 16'd1;
      end else begin
        col_next  = sat_inc(col);
      end
      pcr_next  = !eot && c == cts_pkg::CHAR_CR;
      pbrk_next = !eot && (c == cts_pkg::CHAR_CR || c == cts_pkg::CHAR_LF ||
                           c == cts_pkg::CHAR_BANG);

      if (eot || !(c == cts_pkg::CHAR_SPACE || c == cts_pkg::CHAR_TAB)) begin
        case (cur)
          cts_pkg::MODE_ZERO: begin
            if (!eot && (ch == cts_pkg::CHAR_LX || ch == cts_pkg::CHAR_UX)) begin
              mode_next = cts_pkg::MODE_HEXX;
            end else if (chd) begin
              acc_next  = VALUE_BITS'(ch[3:0]);
              mode_next = cts_pkg::MODE_DEC;
            end else begin
              emit0 = 1'b1;
              tok0.token_kind   = cts_pkg::KIND_DEC;
              tok0.number_value = NB'(acc);
              do_start = 1'b1;
            end
          end
          cts_pkg::MODE_HEXX: begin
            if (chh) begin
              acc_next  = VALUE_BITS'(hex_value(ch));
              mode_next = cts_pkg::MODE_HEX;
            end else begin
              emit0 = 1'b1;
              tok0.token_kind = cts_pkg::KIND_UNKNOWN;
              do_start = 1'b1;
            end
          end
          cts_pkg::MODE_HEX: begin
            if (chh) begin
              acc_next = (acc << 4) | VALUE_BITS'(hex_value(ch));
            end else begin
              emit0 = 1'b1;
              tok0.token_kind   = cts_pkg::KIND_HEX;
              tok0.number_value = NB'(acc);
              do_start = 1'b1;
            end
          end
          cts_pkg::MODE_DEC: begin
            if (chd) begin
              acc_next = acc_x10;
            end else begin
              emit0 = 1'b1;
              tok0.token_kind   = cts_pkg::KIND_DEC;
              tok0.number_value = NB'(acc);
              do_start = 1'b1;
            end
          end
          cts_pkg::MODE_IDENT: begin
            if (chd || cha) begin
              if (icnt < 3'(IDENT_LIMIT)) begin
                ibuf_next = ibuf | (IB'(to_lower(ch)) << {icnt, 3'b000});
                icnt_next = icnt + 3'd1;
              end else begin
                // too long: unknown, the extra character is consumed
                emit0 = 1'b1;
                tok0.token_kind = cts_pkg::KIND_UNKNOWN;
                mode_next = cts_pkg::MODE_IDLE;
              end
            end else begin
              emit0 = 1'b1;
              tok0.token_kind   = cts_pkg::KIND_IDENT;
              tok0.ident_text   = ibuf;
              tok0.ident_length = icnt;
              do_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase

        if (do_start) begin
          sline_next = line_next;
          scol_next  = col_next;
          mode_next  = cts_pkg::MODE_IDLE;
          tok1.token_line   = line_next;
          tok1.token_column = col_next;
          if (!eot && (ch == cts_pkg::CHAR_CR || ch == cts_pkg::CHAR_LF)) begin
            emit1 = !skip_newlines;
            tok1.token_kind = cts_pkg::KIND_NEWLINE;
          end else if (eot) begin
            emit1 = 1'b1;
            tok1.token_kind = cts_pkg::KIND_END;
          end else if (term_hit) begin
            emit1 = 1'b1;
            tok1.token_kind    = cts_pkg::KIND_TERMINAL;
            tok1.terminal_slot = term_slot;
          end else if (chd) begin
            acc_next  = VALUE_BITS'(ch[3:0]);
            mode_next = (ch == cts_pkg::CHAR_ZERO) ? cts_pkg::MODE_ZERO : cts_pkg::MODE_DEC;
          end else if (cha) begin
            ibuf_next = IB'(to_lower(ch));
            icnt_next = 3'd1;
            mode_next = cts_pkg::MODE_IDENT;
          end else begin
            emit1 = 1'b1;
            tok1.token_kind = cts_pkg::KIND_UNKNOWN;
          end
          if (!eot && c == cts_pkg::CHAR_BANG) mode_next = cts_pkg::MODE_COMMENT;
        end
      end
    end
  end

  // pack the group, first token in r0
  always_comb begin
    pair_new = '0;
    if (emit0) begin
      pair_new.r0 = tok0;
      pair_new.r0.last_of_run = !emit1;
      pair_new.r1 = tok1;
      pair_new.r1.last_of_run = 1'b1;
      pair_new.two = emit1;
    end else begin
      pair_new.r0 = tok1;
      pair_new.r0.last_of_run = 1'b1;
    end
  end

  assign in_ready   = (q_count != 2'd2);
  assign in_accept  = in_valid && in_ready;
  assign out_valid  = (q_count != 2'd0);
  assign out_data   = head_sub ? q[0].r1 : q[0].r0;
  assign out_accept = out_valid && out_ready;
  assign pop        = out_accept && (!q[0].two || head_sub);
  assign push       = in_accept && (emit0 || emit1);
  assign wr_pos     = 1'(q_count - {1'b0, pop});
  assign cfg_ready  = 1'b1;
  assign icnt_ok    = icnt != 3'd0 && icnt <= 3'(IDENT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_chars <= '0;
      terminal_count <= '0;
      skip_newlines  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cts_pkg::REG_TERMINAL_CHARS: terminal_chars <= cfg_data;
        cts_pkg::REG_TERMINAL_COUNT: terminal_count <= cfg_data[3:0];
        cts_pkg::REG_SKIP_NEWLINES:  skip_newlines  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= cts_pkg::MODE_IDLE;
      acc   <= '0;
      ibuf  <= '0;
      icnt  <= '0;
      line  <= 16'd1;
      col   <= '0;
      sline <= 16'd1;
      scol  <= '0;
      pcr   <= 1'b0;
      pbrk  <= 1'b0;
    end else if (in_accept) begin
      mode  <= mode_next;
      acc   <= acc_next;
      ibuf  <= ibuf_next;
      icnt  <= icnt_next;
      line  <= line_next;
      col   <= col_next;
      sline <= sline_next;
      scol  <= scol_next;
      pcr   <= pcr_next;
      pbrk  <= pbrk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count  <= '0;
      head_sub <= 1'b0;
    end else begin
      q_count <= q_count - {1'b0, pop} + {1'b0, push};
      if (pop) head_sub <= 1'b0;
      else if (out_accept) head_sub <= 1'b1;
    end
  end

  // payload queue, shift on pop then write behind the survivors
  always_ff @(posedge clk) begin
    if (push && !wr_pos) q[0] <= pair_new;
    else if (pop) q[0] <= q[1];
    if (push && wr_pos) q[1] <= pair_new;
  end

  `CTS_ASSERT_ALWAYS(a_q_bound, q_count != 2'd3, "result queue overflow")
  `CTS_ASSERT_IMPL(a_comment_brk, mode == cts_pkg::MODE_COMMENT, pbrk, "comment without break")
  `CTS_ASSERT_IMPL(a_cr_brk, pcr, pbrk, "CR not marked as break")
  `CTS_ASSERT_IMPL(a_ident_cnt, mode == cts_pkg::MODE_IDENT, icnt_ok, "bad identifier count")
  `CTS_ASSERT_NEXT(a_end_tok, in_accept && in_data.end_of_text, out_valid, "end gave no token")

endmodule

`default_nettype wire

[bench/char_token_scanner_checker.sv]
// Checker for the token scanner: predicts tokens per accepted character and compares.
module char_token_scanner_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  cts_pkg::in_t                       in_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  cts_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [cts_pkg::TERM_CHAR_BITS-1:0] cfg_data,
  output int                                 mismatch_count,
  output int                                 tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam int POS_MAX     = 65535;
  localparam int NB          = cts_pkg::NUMBER_BITS;

  // register copies
  logic [cts_pkg::TERM_CHAR_BITS-1:0] term_chars;
  logic [3:0]                         term_count;
  logic                               skip_nl;

  // scanner state
  cts_pkg::mode_t                  mode;
  logic [NB-1:0]                   acc;
  logic [cts_pkg::IDENT_BITS-1:0]  ident_buf;
  int                              ident_len;
  int                              line_no;
  int                              col_no;
  int                              tok_line;
  int                              tok_col;
  bit                              after_cr;
  bit                              after_break;

  // tokens caused by the current character
  cts_pkg::out_t burst [2];
  int            burst_n;

  cts_pkg::out_t expected_tokens [$];

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= cts_pkg::CHAR_ZERO && ch <= cts_pkg::CHAR_NINE;
  endfunction

  function automatic bit is_letter(logic [7:0] ch);
    return (ch >= cts_pkg::CHAR_LA && ch <= cts_pkg::CHAR_LZ) ||
           (ch >= cts_pkg::CHAR_UA && ch <= cts_pkg::CHAR_UZ);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] ch);
    return (ch >= cts_pkg::CHAR_UA && ch <= cts_pkg::CHAR_UZ) ?
           ch + (cts_pkg::CHAR_LA - cts_pkg::CHAR_UA) : ch;
  endfunction

  // -1 when not a hex digit
  function automatic int hex_value(logic [7:0] ch, bit at_end);
    if (at_end) return -1;
    if (is_digit(ch)) return int'(ch - cts_pkg::CHAR_ZERO);
    if (ch >= cts_pkg::CHAR_LA && ch <= cts_pkg::CHAR_LF_LO)
      return int'(ch - cts_pkg::CHAR_LA + cts_pkg::HEX_ALPHA_BASE);
    if (ch >= cts_pkg::CHAR_UA && ch <= cts_pkg::CHAR_UF)
      return int'(ch - cts_pkg::CHAR_UA + cts_pkg::HEX_ALPHA_BASE);
    return -1;
  endfunction

  function automatic void clear_scanner();
    term_chars  = '0;
    term_count  = '0;
    skip_nl     = 1'b0;
    mode        = cts_pkg::MODE_IDLE;
    acc         = '0;
    ident_buf   = '0;
    ident_len   = 0;
    line_no     = 1;
    col_no      = 0;
    tok_line    = 1;
    tok_col     = 0;
    after_cr    = 1'b0;
    after_break = 1'b0;
  endfunction

  function automatic void write_register(logic [1:0] idx,
                                         logic [cts_pkg::TERM_CHAR_BITS-1:0] data);
    case (idx)
      cts_pkg::REG_TERMINAL_CHARS: term_chars = data;
      cts_pkg::REG_TERMINAL_COUNT: term_count = data[3:0];
      cts_pkg::REG_SKIP_NEWLINES:  skip_nl = data[0];
      default: ;
    endcase
  endfunction

  function automatic void note_token(cts_pkg::kind_t k, logic [2:0] slot, logic [NB-1:0] val,
                                     logic [cts_pkg::IDENT_BITS-1:0] txt, logic [2:0] len);
    cts_pkg::out_t t;
    if (k == cts_pkg::KIND_NEWLINE && skip_nl) return;
    if (burst_n >= 2) return;
    t.token_kind    = k;
    t.terminal_slot = slot;
    t.number_value  = val;
    t.ident_text    = txt;
    t.ident_length  = len;
    t.token_line    = tok_line[15:0];
    t.token_column  = tok_col[15:0];
    t.last_of_run   = 1'b0;
    burst[burst_n]  = t;
    burst_n++;
  endfunction

  // ch taken as the first character of a new token
  function automatic void begin_token(bit at_end, logic [7:0] ch);
    int n;
    tok_line = line_no;
    tok_col  = col_no;
    mode     = cts_pkg::MODE_IDLE;
    if (at_end) begin
      note_token(cts_pkg::KIND_END, '0, '0, '0, '0);
      return;
    end
    if (ch == cts_pkg::CHAR_CR || ch == cts_pkg::CHAR_LF) begin
      note_token(cts_pkg::KIND_NEWLINE, '0, '0, '0, '0);
      return;
    end
    n = (term_count > cts_pkg::MAX_SLOTS) ? cts_pkg::MAX_SLOTS : int'(term_count);
    for (int k = 0; k < n; k++) begin
      if (term_chars[8*k +: 8] == ch) begin
        note_token(cts_pkg::KIND_TERMINAL, k[2:0], '0, '0, '0);
        return;
      end
    end
    if (is_digit(ch)) begin
      acc  = NB'(ch - cts_pkg::CHAR_ZERO);
      mode = (ch == cts_pkg::CHAR_ZERO) ? cts_pkg::MODE_ZERO : cts_pkg::MODE_DEC;
      return;
    end
    if (is_letter(ch)) begin
      ident_buf      = '0;
      ident_buf[7:0] = to_lower(ch);
      ident_len      = 1;
      mode           = cts_pkg::MODE_IDENT;
      return;
    end
    note_token(cts_pkg::KIND_UNKNOWN, '0, '0, '0, '0);
  endfunction

  function automatic void scan_char(cts_pkg::in_t item);
    logic [7:0] c;
    logic [7:0] ch;
    bit         eot;
    int         hv;
    c       = item.char_code;
    eot     = item.end_of_text;
    burst_n = 0;

    if (!eot) begin
      if (mode == cts_pkg::MODE_COMMENT) begin
        if (c == cts_pkg::CHAR_LF) mode = cts_pkg::MODE_IDLE;
        return;
      end
      // LF of a CR LF pair is swallowed
      if (after_cr && c == cts_pkg::CHAR_LF) begin
        after_cr = 1'b0;
        return;
      end
    end else if (mode == cts_pkg::MODE_COMMENT) begin
      mode = cts_pkg::MODE_IDLE;
    end

    if (after_break) begin
      if (line_no < POS_MAX) line_no++;
      col_no = 1;
    end else if (col_no < POS_MAX) begin
      col_no++;
    end
    after_cr    = !eot && c == cts_pkg::CHAR_CR;
    after_break = !eot && (c == cts_pkg::CHAR_CR || c == cts_pkg::CHAR_LF ||
                           c == cts_pkg::CHAR_BANG);

    if (!eot && (c == cts_pkg::CHAR_SPACE || c == cts_pkg::CHAR_TAB)) return;

    ch = (c == cts_pkg::CHAR_BANG) ? cts_pkg::CHAR_LF : c;
    hv = hex_value(ch, eot);

    case (mode)
      cts_pkg::MODE_ZERO: begin
        if (!eot && (ch == cts_pkg::CHAR_LX || ch == cts_pkg::CHAR_UX)) begin
          mode = cts_pkg::MODE_HEXX;
          return;
        end
        if (!eot && is_digit(ch)) begin
          acc  = NB'(ch - cts_pkg::CHAR_ZERO);
          mode = cts_pkg::MODE_DEC;
          return;
        end
        note_token(cts_pkg::KIND_DEC, '0, acc, '0, '0);
      end
      cts_pkg::MODE_HEXX: begin
        if (hv >= 0) begin
          acc  = NB'(hv);
          mode = cts_pkg::MODE_HEX;
          return;
        end
        // unknown at the zero; this character is rescanned below
        note_token(cts_pkg::KIND_UNKNOWN, '0, '0, '0, '0);
      end
      cts_pkg::MODE_HEX: begin
        if (hv >= 0) begin
          acc = acc * NB'(16) + NB'(hv);
          return;
        end
        note_token(cts_pkg::KIND_HEX, '0, acc, '0, '0);
      end
      cts_pkg::MODE_DEC: begin
        if (!eot && is_digit(ch)) begin
          acc = acc * NB'(10) + NB'(ch - cts_pkg::CHAR_ZERO);
          return;
        end
        note_token(cts_pkg::KIND_DEC, '0, acc, '0, '0);
      end
      cts_pkg::MODE_IDENT: begin
        if (!eot && (is_letter(ch) || is_digit(ch))) begin
          if (ident_len < cts_pkg::DEF_IDENT_CAPACITY - 1 && ident_len < 7) begin
            ident_buf[8*ident_len +: 8] = to_lower(ch);
            ident_len++;
          end else begin
            // over-long: the extra character is consumed
            note_token(cts_pkg::KIND_UNKNOWN, '0, '0, '0, '0);
            mode = cts_pkg::MODE_IDLE;
          end
          return;
        end
        note_token(cts_pkg::KIND_IDENT, '0, '0, ident_buf, ident_len[2:0]);
      end
      default: ;
    endcase

    begin_token(eot, ch);
    if (!eot && c == cts_pkg::CHAR_BANG) mode = cts_pkg::MODE_COMMENT;
  endfunction

  function automatic string token_str(cts_pkg::out_t t);
    return $sformatf("kind=%0d slot=%0d value=%h text=%h len=%0d at %0d:%0d last=%0d",
                     t.token_kind, t.terminal_slot, t.number_value, t.ident_text,
                     t.ident_length, t.token_line, t.token_column, t.last_of_run);
  endfunction

  function automatic string field_diff(cts_pkg::out_t got, cts_pkg::out_t want);
    string s;
    s = "";
    if (got.token_kind    !== want.token_kind)    s = {s, " kind"};
    if (got.terminal_slot !== want.terminal_slot) s = {s, " slot"};
    if (got.number_value  !== want.number_value)  s = {s, " value"};
    if (got.ident_text    !== want.ident_text)    s = {s, " text"};
    if (got.ident_length  !== want.ident_length)  s = {s, " len"};
    if (got.token_line    !== want.token_line)    s = {s, " line"};
    if (got.token_column  !== want.token_column)  s = {s, " column"};
    if (got.last_of_run   !== want.last_of_run)   s = {s, " last"};
    return s;
  endfunction

  always @(posedge clk) begin
    cts_pkg::out_t want;
    string         bad;
    if (rst) begin
      clear_scanner();
      expected_tokens.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        scan_char(in_data);
        if (burst_n > 0) burst[burst_n-1].last_of_run = 1'b1;
        for (int i = 0; i < burst_n; i++) expected_tokens.push_back(burst[i]);
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected token: %s", token_str(out_data));
        end else begin
          want = expected_tokens.pop_front();
          bad  = field_diff(out_data, want);
          if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("token mismatch in%s", bad);
              $display("  expected %s", token_str(want));
              $display("  actual   %s", token_str(out_data));
            end
          end
        end
      end
    end
    tokens_pending = expected_tokens.size();
  end

endmodule

[bench/char_token_scanner_tb.sv]
// Top of the token scanner bench: clock, reset, character stimulus and verdict.
module char_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_STALL    = 200;
  localparam int MAX_GAP       = 5;

  localparam logic [63:0] TERMS_OPS   = 64'h3B_78_29_28_2F_2A_2D_2B; // + - * / ( ) x ;
  localparam logic [63:0] TERMS_ODD   = 64'hFF_00_71_35_0A_0D_21_20; // blank ! CR LF 5 q 00 FF
  localparam logic [63:0] TERMS_ZEROS = 64'h0000_0000_3000_0000;     // '0' in slot 3

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  cts_pkg::in_t                       in_data   = '0;
  logic                               in_ready;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  cts_pkg::out_t                      out_data;
  logic                               cfg_valid = 1'b0;
  logic [1:0]                         cfg_index = '0;
  logic [cts_pkg::TERM_CHAR_BITS-1:0] cfg_data  = '0;
  logic                               cfg_ready;

  int mismatches;
  int tokens_pending;

  bit                                 idle_on        = 1'b1;
  bit                                 long_stall_req = 1'b0;
  int                                 chars_sent     = 0;
  int                                 cycle_count    = 0;
  logic [cts_pkg::TERM_CHAR_BITS-1:0] term_table     = '0;
  int                                 term_used      = 0;

  char_token_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  char_token_scanner_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .tokens_pending (tokens_pending)
  );

  always #4 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // token sink: random back-pressure, one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        hold = LONG_STALL;
        long_stall_req = 1'b0;
      end else begin
        hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic push_char(cts_pkg::in_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic push_byte(logic [7:0] b);
    cts_pkg::in_t item;
    item.char_code   = b;
    item.end_of_text = 1'b0;
    push_char(item);
  endtask

  task automatic push_end();
    cts_pkg::in_t item;
    item.char_code   = 8'($urandom_range(0, 255));
    item.end_of_text = 1'b1;
    push_char(item);
  endtask

  // stop offering and wait until every predicted token has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [cts_pkg::TERM_CHAR_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [cts_pkg::TERM_CHAR_BITS-1:0] chars, logic [3:0] count,
                           logic skip);
    drain_results();
    write_cfg(cts_pkg::REG_TERMINAL_CHARS, chars);
    write_cfg(cts_pkg::REG_TERMINAL_COUNT, {60'd0, count});
    write_cfg(cts_pkg::REG_SKIP_NEWLINES, {63'd0, skip});
    term_table = chars;
    term_used  = (count > cts_pkg::MAX_SLOTS) ? cts_pkg::MAX_SLOTS : int'(count);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? cts_pkg::CHAR_LA : cts_pkg::CHAR_UA) +
           8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return cts_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < cts_pkg::HEX_ALPHA_BASE) return cts_pkg::CHAR_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? cts_pkg::CHAR_LA : cts_pkg::CHAR_UA) + 8'(v) -
           cts_pkg::HEX_ALPHA_BASE;
  endfunction

  // one lexeme, mostly well formed, some noise
  task automatic send_lexeme();
    int pick;
    int n;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(1, 9);
      push_byte(rand_letter());
      repeat (n - 1) push_byte($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
    end else if (pick < 34) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        push_byte(rand_digit());
        if ($urandom_range(0, 9) == 0)
          push_byte($urandom_range(0, 1) ? cts_pkg::CHAR_SPACE : cts_pkg::CHAR_TAB);
      end
    end else if (pick < 48) begin
      push_byte(cts_pkg::CHAR_ZERO);
      push_byte($urandom_range(0, 1) ? cts_pkg::CHAR_LX : cts_pkg::CHAR_UX);
      n = $urandom_range(0, 10);
      repeat (n) push_byte(rand_hex_char());
    end else if (pick < 58) begin
      if (term_used == 0) begin
        push_byte("+");
      end else begin
        k = $urandom_range(0, term_used - 1);
        push_byte(term_table[8*k +: 8]);
      end
    end else if (pick < 66) begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte($urandom_range(0, 1) ? cts_pkg::CHAR_SPACE : cts_pkg::CHAR_TAB);
    end else if (pick < 76) begin
      case ($urandom_range(0, 3))
        0: push_byte(cts_pkg::CHAR_CR);
        1: push_byte(cts_pkg::CHAR_LF);
        2: begin
          push_byte(cts_pkg::CHAR_CR);
          push_byte(cts_pkg::CHAR_LF);
        end
        default: begin
          push_byte(cts_pkg::CHAR_LF);
          push_byte(cts_pkg::CHAR_CR);
        end
      endcase
    end else if (pick < 81) begin
      push_byte(cts_pkg::CHAR_BANG);
      n = $urandom_range(0, 5);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) push_end();
      else push_byte(cts_pkg::CHAR_LF);
    end else if (pick < 84) begin
      push_end();
    end else begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = chars_sent;
    while (chars_sent - start < count) send_lexeme();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(TERMS_OPS, 4'd8, 1'b0);

    // identifier closed by a terminal: two tokens from one character
    push_byte(cts_pkg::CHAR_UA);
    push_byte(cts_pkg::CHAR_LZ);
    push_byte(cts_pkg::CHAR_ZERO);
    push_byte("+");
    // 0x with no hex digit, then the g is rescanned
    push_byte(cts_pkg::CHAR_ZERO);
    push_byte(cts_pkg::CHAR_LX);
    push_byte("g");
    // CR LF is one break
    push_byte(cts_pkg::CHAR_CR);
    push_byte(cts_pkg::CHAR_LF);
    // hex in both cases, ended by a comment
    push_byte(cts_pkg::CHAR_ZERO);
    push_byte(cts_pkg::CHAR_UX);
    push_byte(cts_pkg::CHAR_LF_LO);
    push_byte(cts_pkg::CHAR_UF);
    push_byte(cts_pkg::CHAR_BANG);
    push_byte(cts_pkg::CHAR_LF);
    // over-long identifier
    push_byte("a");
    push_byte("b");
    push_byte("c");
    push_byte("d");
    push_byte("e");
    push_byte("f");
    push_byte("g");
    push_byte("h");
    // bytes outside the letters and digits
    push_byte(8'hFF);
    push_byte(8'h00);
    // flush on end, then a second end
    push_byte(cts_pkg::CHAR_NINE);
    push_end();
    push_end();

    random_phase(150);
    long_stall_req = 1'b1;
    random_phase(150);

    configure(TERMS_ODD, 4'd15, 1'b1);
    random_phase(150);
    drain_results();
    random_phase(150);

    idle_on = 1'b0;
    configure('0, 4'd0, 1'b0);
    random_phase(300);
    idle_on = 1'b1;

    configure('1, 4'd1, 1'b1);
    random_phase(300);

    configure(TERMS_ZEROS, 4'd8, 1'b0);
    random_phase(300);

    configure(TERMS_OPS, 4'd8, 1'b1);
    random_phase(30);

    drain_results();
    if (mismatches == 0 && tokens_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[char_token_scanner.f]
+incdir+rtl
rtl/cts_pkg.sv
rtl/char_token_scanner.sv
bench/char_token_scanner_checker.sv
bench/char_token_scanner_tb.sv
